// ===== rtl/core/dli_pkg.sv =====
// ---------------------------------------------------------------------------
// dli_pkg
// Shared types and constants of the dda linear interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dli_pkg;

   localparam int VALUE_W = 8;
   localparam int ERR_W   = 10;
   localparam int CALC_W  = 12;

   localparam logic       ACTION_START = 1'b0;
   localparam logic       ACTION_STEP  = 1'b1;

   localparam logic [1:0] MODE_EQUAL   = 2'd0;
   localparam logic [1:0] MODE_GREATER = 2'd1;
   localparam logic [1:0] MODE_SMALLER = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch the request fields
      logic exec_single;  // start, equal or smaller step as one update
      logic loop_sub;     // one greater-mode iteration
      logic loop_add;     // greater-mode closing add
      logic load_out;     // copy the value into the response register
   } dli_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic step_loop;    // captured request is a greater-mode step
      logic loop_more;    // twice the error still reaches the step count
   } dli_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/dli_ctrl.sv =====
// ---------------------------------------------------------------------------
// dli_ctrl
// Sequencer: accepts a request, runs the datapath, hands over the response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dli_ctrl
   import dli_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire dli_status_type status,
   output dli_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.step_loop) begin
               if (status.loop_more) begin
                  cmd.loop_sub = 1'b1;
               end else begin
                  cmd.loop_add = 1'b1;
                  state_in     = ST_EMIT;
               end
            end else begin
               cmd.exec_single = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dli_dp.sv =====
// ---------------------------------------------------------------------------
// dli_dp
// Datapath: run registers, error accumulator and response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dli_dp
   import dli_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_action,
   input  wire logic [VALUE_W-1:0] req_start,
   input  wire logic [VALUE_W-1:0] req_end,
   input  wire logic [VALUE_W-1:0] req_steps,
   input  wire dli_cmd_type        cmd,
   output dli_status_type          status,
   output logic [VALUE_W-1:0]      rsp_value
);

   // captured request
   logic               act_ff;
   logic [VALUE_W-1:0] start_ff, end_ff, count_ff;

   // run state
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [VALUE_W-1:0] dist_ff, dist_in;
   logic [VALUE_W-1:0] steps_ff, steps_in;
   logic               down_ff, down_in;
   logic [1:0]         mode_ff, mode_in;
   logic [VALUE_W-1:0] out_ff;

   logic signed [CALC_W-1:0] err_ext, steps_ext, dist_ext;
   logic signed [CALC_W-1:0] err_less_dist, err_less_steps, err_plus_dist;
   logic [VALUE_W-1:0]       moved;
   logic [VALUE_W-1:0]       new_steps, new_dist;
   logic                     new_up;

   assign err_ext   = CALC_W'(signed'(err_ff));
   assign steps_ext = signed'(CALC_W'(steps_ff));
   assign dist_ext  = signed'(CALC_W'(dist_ff));

   assign err_less_dist  = err_ext - dist_ext;
   assign err_less_steps = err_ext - steps_ext;
   assign err_plus_dist  = err_ext + dist_ext;
   assign moved          = down_ff ? value_ff - 1'b1 : value_ff + 1'b1;

   assign new_steps = (count_ff == '0) ? VALUE_W'(1) : count_ff;
   assign new_up    = end_ff > start_ff;
   assign new_dist  = new_up ? end_ff - start_ff : start_ff - end_ff;

   assign status.step_loop = (act_ff == ACTION_STEP) && (mode_ff == MODE_GREATER);
   assign status.loop_more = (err_ext <<< 1) >= steps_ext;
   assign rsp_value        = out_ff;

   always_comb begin
      value_in = value_ff;
      err_in   = err_ff;
      dist_in  = dist_ff;
      steps_in = steps_ff;
      down_in  = down_ff;
      mode_in  = mode_ff;
      priority if (cmd.exec_single) begin
         if (act_ff == ACTION_START) begin
            value_in = start_ff;
            steps_in = new_steps;
            dist_in  = new_dist;
            down_in  = !new_up;
            priority if (new_dist > new_steps) begin
               mode_in = MODE_GREATER;
               err_in  = ERR_W'(new_dist);
            end else if (new_dist < new_steps) begin
               mode_in = MODE_SMALLER;
               err_in  = ERR_W'(new_steps);
            end else begin
               mode_in = MODE_EQUAL;
               err_in  = '0;
            end
         end else begin
            unique case (mode_ff)
               MODE_EQUAL: begin
                  value_in = moved;
               end
               MODE_SMALLER: begin
                  if ((err_less_dist <<< 1) < steps_ext) begin
                     err_in   = ERR_W'(err_less_dist + steps_ext);
                     value_in = moved;
                  end else begin
                     err_in = ERR_W'(err_less_dist);
                  end
               end
               default: begin
                  // greater mode (run by the loop commands) and the unused code hold the value
               end
            endcase
         end
      end else if (cmd.loop_sub) begin
         err_in   = ERR_W'(err_less_steps);
         value_in = moved;
      end else if (cmd.loop_add) begin
         err_in = ERR_W'(err_plus_dist);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         err_ff   <= '0;
         dist_ff  <= '0;
         steps_ff <= VALUE_W'(1);
         down_ff  <= 1'b0;
         mode_ff  <= MODE_EQUAL;
      end else begin
         value_ff <= value_in;
         err_ff   <= err_in;
         dist_ff  <= dist_in;
         steps_ff <= steps_in;
         down_ff  <= down_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         start_ff <= req_start;
         end_ff   <= req_end;
         count_ff <= req_steps;
      end
      if (cmd.load_out) begin
         out_ff <= value_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dda_linear_interpolator.sv =====
// ---------------------------------------------------------------------------
// dda_linear_interpolator
// Walks an 8-bit value from a start to an end value over a step count.
//
// req channel: tuser = action (0 start a run, 1 advance one step),
//   tdata = start_value, end_value, step_count. A step count of 0 counts as 1.
// rsp channel: one response per request carrying the value after it.
// One request is in work at a time. A start or an equal/smaller step passes
//   from acceptance through the run and hand-over states to rsp_tvalid; a
//   greater-mode step stays in the run state for one subtract on the error
//   accumulator per unit the value moves, then a closing add.
//   req_tready rises again the cycle after the response loads.
// The response sits in an output register, so the next request is accepted
//   and computed while an earlier response is still waiting; a stalled
//   receiver only holds the block in its hand-over state.
// Synchronous reset gives value 0, step count 1, equal mode, counting up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dda_linear_interpolator
   import dli_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // start_value, end_value, step_count
   input  wire logic        req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // current_value
);

   dli_cmd_type    cmd;
   dli_status_type status;

   dli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dli_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_action (req_tuser),
      .req_start  (req_tdata[7:0]),
      .req_end    (req_tdata[15:8]),
      .req_steps  (req_tdata[23:16]),
      .cmd        (cmd),
      .status     (status),
      .rsp_value  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== rtl/core/dli_checker.sv =====
// ---------------------------------------------------------------------------
// dli_checker
// Port-level checks of the interpolator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dli_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   // no response is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request in work: no second acceptance right after one
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while one is in work");

   // with no response pending, an accepted request does not show its response in the next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind dda_linear_interpolator dli_checker u_dli_checker (.*);

`default_nettype wire

// ===== sim/dda_linear_interpolator_test.sv =====
// ---------------------------------------------------------------------------
// dda_linear_interpolator_test
// Drives start and step requests into the interpolator with random gaps and
// response back-pressure, predicts every returned value from its own copy of
// the run state, and compares each response with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_linear_interpolator_test;
   import dli_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_REQS = 1900;

   // holds the interpolation state and the queue of values still owed
   class interp_scoreboard;
      logic [7:0] value_now;
      int         err_acc;
      logic [7:0] run_dist;
      logic [7:0] steps;
      logic       moving_down;
      logic [1:0] run_mode;
      logic [7:0] owed_values[$];
      int         failures;

      function new();
         value_now   = 8'd0;
         err_acc     = 0;
         run_dist    = 8'd0;
         steps       = 8'd1;
         moving_down = 1'b0;
         run_mode    = MODE_EQUAL;
         failures    = 0;
      endfunction

      function int wrap10(int v);
         logic [9:0] bits;
         bits = v[9:0];
         return int'($signed(bits));
      endfunction

      function void move_one();
         if (moving_down) value_now = value_now - 8'd1;
         else value_now = value_now + 8'd1;
      endfunction

      function void note_request(logic act, logic [7:0] s, logic [7:0] e, logic [7:0] n);
         if (act == ACTION_START) begin
            steps     = (n == 8'd0) ? 8'd1 : n;
            value_now = s;
            if (e > s) begin
               run_dist    = e - s;
               moving_down = 1'b0;
            end else begin
               run_dist    = s - e;
               moving_down = 1'b1;
            end
            if (run_dist > steps) begin
               run_mode = MODE_GREATER;
               err_acc  = int'(run_dist);
            end else if (run_dist < steps) begin
               run_mode = MODE_SMALLER;
               err_acc  = int'(steps);
            end else begin
               run_mode = MODE_EQUAL;
               err_acc  = 0;
            end
         end else begin
            case (run_mode)
               MODE_EQUAL: begin
                  move_one();
               end
               MODE_GREATER: begin
                  while (err_acc * 2 >= int'(steps)) begin
                     err_acc = wrap10(err_acc - int'(steps));
                     move_one();
                  end
                  err_acc = wrap10(err_acc + int'(run_dist));
               end
               MODE_SMALLER: begin
                  err_acc = wrap10(err_acc - int'(run_dist));
                  if (err_acc * 2 < int'(steps)) begin
                     err_acc = wrap10(err_acc + int'(steps));
                     move_one();
                  end
               end
               default: ;
            endcase
         end
         owed_values.push_back(value_now);
      endfunction

      function void check_response(logic [7:0] got);
         logic [7:0] want;
         if (owed_values.size() == 0) begin
            $error("unexpected response current_value=%0d", got);
            failures++;
         end else begin
            want = owed_values.pop_front();
            if (got !== want) begin
               $error("current_value mismatch: expected %0d actual %0d", want, got);
               failures++;
            end
         end
      endfunction

      function int pending();
         return owed_values.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'd0;   // start_value, end_value, step_count
   logic        req_tuser = 1'b0;    // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // current_value

   interp_scoreboard sb = new();
   bit quiet = 1'b0;                 // no idling on either side while set
   int cycles = 0;
   int sent = 0;

   dda_linear_interpolator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: sample the handshake, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 28);
   end

   task automatic send_request(input logic act, input logic [7:0] s, input logic [7:0] e,
                               input logic [7:0] n);
      if (!quiet && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < 40) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {n, e, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, s, e, n);
      sent++;
   endtask

   task automatic send_step();
      send_request(ACTION_STEP, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_run(input logic [7:0] s, input logic [7:0] e, input logic [7:0] n,
                           input int step_reqs);
      send_request(ACTION_START, s, e, n);
      repeat (step_reqs) send_step();
   endtask

   initial begin
      int         pick;
      int         wait_cycles;
      logic [7:0] s, e, n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // steps straight out of reset count up from zero
      send_request(ACTION_STEP, 8'hFF, 8'hFF, 8'hFF);
      send_request(ACTION_STEP, 8'h00, 8'h00, 8'h00);
      send_step();
      send_run(8'd10, 8'd20, 8'd10, 3);        // equal mode
      send_run(8'd0, 8'd255, 8'd1, 2);         // full swing in one step, then past the run
      send_run(8'd255, 8'd0, 8'd0, 2);         // zero step count, downwards
      send_run(8'd77, 8'd77, 8'd5, 2);         // start equals end
      send_run(8'd0, 8'd3, 8'd255, 3);         // smaller mode
      send_run(8'd200, 8'd100, 8'd255, 2);     // smaller mode, downwards
      send_run(8'd255, 8'd255, 8'd0, 1);

      while (sent < RANDOM_REQS + 25) begin
         quiet = (sent > 700 && sent < 1000);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            s = 8'($urandom);
            e = 8'($urandom);
            case ($urandom_range(0, 3))
               0: n = 8'($urandom_range(0, 8));
               1: n = (s > e) ? s - e : e - s;   // aim for equal mode
               default: n = 8'($urandom);
            endcase
            if (n > 8'd40 && $urandom_range(0, 3) != 0) n = 8'($urandom_range(1, 40));
            send_run(s, e, n, $urandom_range(0, int'(n) + 3));
         end else begin
            send_request(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
      quiet = 1'b0;

      @(posedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 20) begin
         @(posedge clock);
         wait_cycles++;
      end

      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== dda_linear_interpolator.f =====
rtl/core/dli_pkg.sv
rtl/core/dli_ctrl.sv
rtl/core/dli_dp.sv
rtl/core/dda_linear_interpolator.sv
rtl/core/dli_checker.sv
sim/dda_linear_interpolator_test.sv
